>>> src/hid_report_item_parser_core_assert.svh
// Assertion macros used by the checker file of the HID item parser.
`ifndef HID_REPORT_ITEM_PARSER_CORE_ASSERT_SVH
`define HID_REPORT_ITEM_PARSER_CORE_ASSERT_SVH

// Checked while out of reset.
`define HRIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HRIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hrip_pkg.sv
// Types and constants of the HID report descriptor item parser.
package hrip_pkg;

    localparam int MAX_DEPTH = 15;
    localparam logic [3:0] DEPTH_LIMIT = (MAX_DEPTH > 15) ? 4'd15 : 4'(MAX_DEPTH);

    localparam logic [2:0] PH_PREFIX     = 3'd0;
    localparam logic [2:0] PH_SHORT_DATA = 3'd1;
    localparam logic [2:0] PH_LONG_SIZE  = 3'd2;
    localparam logic [2:0] PH_LONG_TAG   = 3'd3;
    localparam logic [2:0] PH_LONG_DATA  = 3'd4;

    localparam logic [7:0] LONG_PREFIX = 8'hFE;

    localparam logic [1:0] TYPE_MAIN     = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
    localparam logic [1:0] TYPE_LOCAL    = 2'd2;
    localparam logic [1:0] TYPE_RESERVED = 2'd3;

    localparam logic [3:0] TAG_COLLECTION     = 4'd10;
    localparam logic [3:0] TAG_END_COLLECTION = 4'd12;
    localparam logic [3:0] TAG_USAGE_PAGE     = 4'd0;
    localparam logic [3:0] TAG_MAIN_LOW       = 4'd8;
    localparam logic [3:0] TAG_GLOBAL_HIGH    = 4'd11;
    localparam logic [3:0] TAG_LOCAL_HIGH     = 4'd10;
    localparam logic [3:0] TAG_LOCAL_BAD      = 4'd6;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RESERVED   = 3'd1;
    localparam logic [2:0] ST_BAD_MAIN   = 3'd2;
    localparam logic [2:0] ST_BAD_GLOBAL = 3'd3;
    localparam logic [2:0] ST_BAD_LOCAL  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;

    typedef struct packed {
        logic [1:0]         item_type;
        logic [7:0]         item_tag;
        logic               long_item;
        logic [7:0]         data_length;
        logic [31:0]        value_unsigned;
        logic signed [31:0] value_signed;
        logic [3:0]         nest_depth;
        logic [31:0]        current_usage_page;
        logic [2:0]         status;
        logic               descriptor_end;
    } t_result;

endpackage

>>> src/hrip_parse.sv
// Parser state and per-byte decode of descriptor items.
module hrip_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_has_result,
    output hrip_pkg::t_result o_result
);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_remaining, n_remaining;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_type, n_type;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_length, n_length;
    logic [3:0]  r_depth, n_depth;
    logic [31:0] r_page, n_page;
    logic        r_halted, n_halted;

    logic [2:0]  eff_phase;
    logic [7:0]  byte_offset;
    logic [31:0] placed_byte;
    logic [2:0]  short_len;
    logic        fin_short;
    logic        fin_long;
    logic [2:0]  st;
    logic [3:0]  tag4;
    logic [31:0] sext;

    assign eff_phase   = (r_phase > hrip_pkg::PH_LONG_DATA) ? hrip_pkg::PH_PREFIX : r_phase;
    assign byte_offset = r_length - r_remaining;
    assign short_len   = (i_data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, i_data_byte[1:0]};

    always_comb begin
        case (byte_offset[1:0])
            2'd0:    placed_byte = {24'd0, i_data_byte};
            2'd1:    placed_byte = {16'd0, i_data_byte, 8'd0};
            2'd2:    placed_byte = {8'd0, i_data_byte, 16'd0};
            default: placed_byte = {i_data_byte, 24'd0};
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_acc        = r_acc;
        n_type       = r_type;
        n_tag        = r_tag;
        n_length     = r_length;
        n_depth      = r_depth;
        n_page       = r_page;
        n_halted     = r_halted;
        fin_short    = 1'b0;
        fin_long     = 1'b0;
        st           = hrip_pkg::ST_OK;
        tag4         = 4'd0;
        sext         = 32'd0;
        o_has_result = 1'b0;
        o_result     = '0;

        if (!r_halted) begin
            case (eff_phase)
                hrip_pkg::PH_SHORT_DATA: begin
                    n_acc       = r_acc | placed_byte;
                    n_remaining = r_remaining - 8'd1;
                    fin_short   = (n_remaining == 8'd0);
                end
                hrip_pkg::PH_LONG_SIZE: begin
                    n_length    = i_data_byte;
                    n_remaining = i_data_byte;
                    n_phase     = hrip_pkg::PH_LONG_TAG;
                end
                hrip_pkg::PH_LONG_TAG: begin
                    n_tag = i_data_byte;
                    if (r_remaining == 8'd0) begin
                        fin_long = 1'b1;
                    end else begin
                        n_phase = hrip_pkg::PH_LONG_DATA;
                    end
                end
                hrip_pkg::PH_LONG_DATA: begin
                    n_remaining = r_remaining - 8'd1;
                    fin_long    = (n_remaining == 8'd0);
                end
                default: begin
                    n_acc = 32'd0;
                    if (i_data_byte == hrip_pkg::LONG_PREFIX) begin
                        n_type      = hrip_pkg::TYPE_RESERVED;
                        n_tag       = 8'd0;
                        n_length    = 8'd0;
                        n_remaining = 8'd0;
                        n_phase     = hrip_pkg::PH_LONG_SIZE;
                    end else begin
                        n_type      = i_data_byte[3:2];
                        n_tag       = {4'd0, i_data_byte[7:4]};
                        n_length    = {5'd0, short_len};
                        n_remaining = {5'd0, short_len};
                        if (short_len == 3'd0) begin
                            fin_short = 1'b1;
                        end else begin
                            n_phase = hrip_pkg::PH_SHORT_DATA;
                        end
                    end
                end
            endcase

            if (fin_short) begin
                tag4 = n_tag[3:0];
                case (n_length)
                    8'd0:    sext = 32'd0;
                    8'd1:    sext = {{24{n_acc[7]}}, n_acc[7:0]};
                    8'd2:    sext = {{16{n_acc[15]}}, n_acc[15:0]};
                    default: sext = n_acc;
                endcase
                case (n_type)
                    hrip_pkg::TYPE_MAIN: begin
                        if (tag4 < hrip_pkg::TAG_MAIN_LOW
                            || tag4 > hrip_pkg::TAG_END_COLLECTION) begin
                            st = hrip_pkg::ST_BAD_MAIN;
                        end else if (tag4 == hrip_pkg::TAG_COLLECTION) begin
                            if (r_depth < hrip_pkg::DEPTH_LIMIT) n_depth = r_depth + 4'd1;
                        end else if (tag4 == hrip_pkg::TAG_END_COLLECTION) begin
                            if (r_depth != 4'd0) n_depth = r_depth - 4'd1;
                        end
                    end
                    hrip_pkg::TYPE_GLOBAL: begin
                        if (tag4 > hrip_pkg::TAG_GLOBAL_HIGH) begin
                            st = hrip_pkg::ST_BAD_GLOBAL;
                        end else if (tag4 == hrip_pkg::TAG_USAGE_PAGE) begin
                            n_page = n_acc;
                        end
                    end
                    hrip_pkg::TYPE_LOCAL: begin
                        if (tag4 == hrip_pkg::TAG_LOCAL_BAD
                            || tag4 > hrip_pkg::TAG_LOCAL_HIGH) begin
                            st = hrip_pkg::ST_BAD_LOCAL;
                        end
                    end
                    default: st = hrip_pkg::ST_RESERVED;
                endcase
                // halt on any illegal tag until the descriptor ends
                n_halted = (st == hrip_pkg::ST_BAD_MAIN) || (st == hrip_pkg::ST_BAD_GLOBAL)
                           || (st == hrip_pkg::ST_BAD_LOCAL);
                n_phase  = hrip_pkg::PH_PREFIX;
                o_has_result                = 1'b1;
                o_result.item_type          = n_type;
                o_result.item_tag           = {4'd0, tag4};
                o_result.long_item          = 1'b0;
                o_result.data_length        = n_length;
                o_result.value_unsigned     = n_acc;
                o_result.value_signed       = sext;
                o_result.nest_depth         = n_depth;
                o_result.current_usage_page = n_page;
                o_result.status             = st;
                o_result.descriptor_end     = i_last_byte;
            end else if (fin_long) begin
                n_phase                     = hrip_pkg::PH_PREFIX;
                o_has_result                = 1'b1;
                o_result.item_type          = hrip_pkg::TYPE_RESERVED;
                o_result.item_tag           = n_tag;
                o_result.long_item          = 1'b1;
                o_result.data_length        = n_length;
                o_result.nest_depth         = r_depth;
                o_result.current_usage_page = r_page;
                o_result.status             = hrip_pkg::ST_OK;
                o_result.descriptor_end     = i_last_byte;
            end else if (i_last_byte) begin
                // descriptor ended inside an item
                o_has_result                = 1'b1;
                o_result.item_type          = n_type;
                o_result.item_tag           = n_tag;
                o_result.long_item          = (n_phase >= hrip_pkg::PH_LONG_SIZE);
                o_result.data_length        = n_length;
                o_result.nest_depth         = r_depth;
                o_result.current_usage_page = r_page;
                o_result.status             = hrip_pkg::ST_TRUNCATED;
                o_result.descriptor_end     = 1'b1;
            end
        end

        if (i_last_byte) begin
            n_phase     = hrip_pkg::PH_PREFIX;
            n_remaining = 8'd0;
            n_acc       = 32'd0;
            n_type      = 2'd0;
            n_tag       = 8'd0;
            n_length    = 8'd0;
            n_depth     = 4'd0;
            n_page      = 32'd0;
            n_halted    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hrip_pkg::PH_PREFIX;
            r_remaining <= 8'd0;
            r_acc       <= 32'd0;
            r_type      <= 2'd0;
            r_tag       <= 8'd0;
            r_length    <= 8'd0;
            r_depth     <= 4'd0;
            r_page      <= 32'd0;
            r_halted    <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_type      <= n_type;
            r_tag       <= n_tag;
            r_length    <= n_length;
            r_depth     <= n_depth;
            r_page      <= n_page;
            r_halted    <= n_halted;
        end
    end

endmodule

>>> src/hrip_out_stage.sv
// Result register with valid/ready hand-off to the consumer.
module hrip_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_has_result,
    input  hrip_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output hrip_pkg::t_result o_result
);

    logic              r_valid;
    hrip_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_has_result;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset; load only with a real result
    always_ff @(posedge i_clk) begin
        if (i_load && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

>>> src/hid_report_item_parser_core.sv
// Top level of the HID report descriptor item parser.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------------
//   in      | i_in_valid / o_in_ready | i_data_byte, i_last_byte
//   out     | o_out_valid/ i_out_ready| o_item_type .. o_descriptor_end (ten fields)
//
// One byte a cycle unless a held result stalls it: the byte is decoded out of the input
// register and, when it advances, any result it gives is loaded into the result register.
// The parser state loop (phase, count, accumulator, depth, page) is registered in hrip_parse.
// Synchronous active-low reset clears all control and parser state.
// A stalled result holds the pipe; bytes that give no result pass even while it waits.
module hid_report_item_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_item_type,
    output logic [7:0]         o_item_tag,
    output logic               o_long_item,
    output logic [7:0]         o_data_length,
    output logic [31:0]        o_value_unsigned,
    output logic signed [31:0] o_value_signed,
    output logic [3:0]         o_nest_depth,
    output logic [31:0]        o_current_usage_page,
    output logic [2:0]         o_status,
    output logic               o_descriptor_end
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              advance;
    logic              has_result;
    logic              out_valid;
    hrip_pkg::t_result parse_result;
    hrip_pkg::t_result out_result;

    // the byte in the input register may advance if it gives no result or its result has somewhere to go
    assign advance    = r_in_valid && (!out_valid || i_out_ready || !has_result);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    hrip_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_has_result (has_result),
        .o_result     (parse_result)
    );

    hrip_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && has_result),
        .i_has_result (has_result),
        .i_result     (parse_result),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (out_valid),
        .o_result     (out_result)
    );

    assign o_out_valid          = out_valid;
    assign o_item_type          = out_result.item_type;
    assign o_item_tag           = out_result.item_tag;
    assign o_long_item          = out_result.long_item;
    assign o_data_length        = out_result.data_length;
    assign o_value_unsigned     = out_result.value_unsigned;
    assign o_value_signed       = out_result.value_signed;
    assign o_nest_depth         = out_result.nest_depth;
    assign o_current_usage_page = out_result.current_usage_page;
    assign o_status             = out_result.status;
    assign o_descriptor_end     = out_result.descriptor_end;

endmodule

>>> src/hrip_checker.sv
// Port-level checks on the HID item parser, bound to its top level.
`include "hid_report_item_parser_core_assert.svh"

module hrip_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_item_type,
    input logic [7:0]         o_item_tag,
    input logic               o_long_item,
    input logic [31:0]        o_value_unsigned,
    input logic signed [31:0] o_value_signed,
    input logic [3:0]         o_nest_depth,
    input logic [2:0]         o_status,
    input logic               o_descriptor_end
);

    property p_out_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_value_unsigned) && $stable(o_item_tag);
    endproperty

    property p_long_zero;
        o_out_valid && o_long_item |-> o_value_unsigned == 32'd0 && o_value_signed == 32'sd0
            && o_item_type == hrip_pkg::TYPE_RESERVED;
    endproperty

    property p_trunc_end;
        o_out_valid && o_status == hrip_pkg::ST_TRUNCATED |-> o_descriptor_end
            && o_value_unsigned == 32'd0;
    endproperty

    property p_status_range;
        o_out_valid |-> o_status <= hrip_pkg::ST_TRUNCATED
            && o_nest_depth <= hrip_pkg::DEPTH_LIMIT;
    endproperty

    `HRIP_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")
    `HRIP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `HRIP_ASSERT(a_long_zero, i_clk, i_rst_n, p_long_zero, "long item carries a value")
    `HRIP_ASSERT(a_trunc_end, i_clk, i_rst_n, p_trunc_end, "truncated result not at descriptor end")
    `HRIP_ASSERT(a_status_range, i_clk, i_rst_n, p_status_range, "status code out of range")

endmodule

bind hid_report_item_parser_core hrip_checker u_hrip_checker (.*);
